### rtl/apof_pkg.sv
// Shared constants and types for the all-pairs box overlap filter.
package apof_pkg;

  // Table size and derived widths
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int MASK_W      = 32;
  localparam int LANES       = (MAX_ENTRIES < MASK_W) ? MAX_ENTRIES : MASK_W;
  localparam int SLOT_W      = 5;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int SUM_W   = 17;
  localparam int KIND_W  = 3;

  // Type permission matrix
  localparam int NUM_KINDS = 5;
  localparam int TPM_W     = NUM_KINDS * NUM_KINDS;
  localparam int TPM_IDX_W = $clog2(TPM_W);
  localparam logic [TPM_W-1:0] TPM_RESET = 25'd2239104;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FETCH,
    ST_EMIT
  } apof_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             fetch;
    logic             emit;
    logic             clear;
    logic             row_last;
    logic [IDX_W-1:0] row_idx;
  } apof_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } apof_stat_t;

endpackage

### rtl/apof_ctrl.sv
// Sequencer: load phase, then a fetch/emit pass over every stored row.
module apof_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_final_entry,
  input  apof_pkg::apof_stat_t stat,
  output apof_pkg::apof_cmd_t  cmd,
  output logic                busy
);
  import apof_pkg::*;

  apof_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             is_last;

  assign accept  = start && (state_r == ST_LOAD);
  assign is_last = ((row_r + CNT_W'(1)) == stat.count);

  // State and row counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_final_entry) begin
          state_nxt = ST_FETCH;
          row_nxt   = '0;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (is_last) begin
          state_nxt = ST_LOAD;
          row_nxt   = '0;
        end else begin
          state_nxt = ST_FETCH;
          row_nxt   = row_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        row_nxt   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.row_idx  = row_r[IDX_W-1:0];
    cmd.row_last = is_last;
    busy         = 1'b1;
    case (state_r)
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = accept;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.clear = is_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### rtl/apof_dpath.sv
// Collider table, row latch, parallel overlap lanes and result registers.
module apof_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  apof_pkg::apof_cmd_t                    cmd,
  output apof_pkg::apof_stat_t                   stat,
  input  logic                                   cfg_we,
  input  logic [apof_pkg::TPM_W-1:0]             cfg_data,
  input  logic signed [apof_pkg::COORD_W-1:0]    in_box_left,
  input  logic signed [apof_pkg::COORD_W-1:0]    in_box_top,
  input  logic [apof_pkg::SIZE_W-1:0]            in_box_width,
  input  logic [apof_pkg::SIZE_W-1:0]            in_box_height,
  input  logic [apof_pkg::KIND_W-1:0]            in_kind,
  input  logic                                   in_enabled,
  input  logic                                   in_has_receiver,
  output logic                                   out_valid,
  output logic [apof_pkg::SLOT_W-1:0]            out_receiver_slot,
  output logic [apof_pkg::MASK_W-1:0]            out_partner_mask,
  output logic                                   out_row_last
);
  import apof_pkg::*;

  // Configuration register
  logic [TPM_W-1:0] tpm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tpm_r <= TPM_RESET;
    else if (cfg_we) tpm_r <= cfg_data;
  end

  // Entry count
  logic [CNT_W-1:0] count_r;
  logic             full;

  assign full       = (count_r == CNT_W'(MAX_ENTRIES));
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.load && !full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Collider table (no reset, only entries below the count are used)
  logic signed [COORD_W-1:0] left_r   [MAX_ENTRIES];
  logic signed [COORD_W-1:0] top_r    [MAX_ENTRIES];
  logic [SIZE_W-1:0]         width_r  [MAX_ENTRIES];
  logic [SIZE_W-1:0]         height_r [MAX_ENTRIES];
  logic [KIND_W-1:0]         kind_r   [MAX_ENTRIES];
  logic                      en_r     [MAX_ENTRIES];
  logic                      rx_r     [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      left_r[count_r[IDX_W-1:0]]   <= in_box_left;
      top_r[count_r[IDX_W-1:0]]    <= in_box_top;
      width_r[count_r[IDX_W-1:0]]  <= in_box_width;
      height_r[count_r[IDX_W-1:0]] <= in_box_height;
      kind_r[count_r[IDX_W-1:0]]   <= in_kind;
      en_r[count_r[IDX_W-1:0]]     <= in_enabled;
      rx_r[count_r[IDX_W-1:0]]     <= in_has_receiver;
    end
  end

  // Row fetch: select the receiving collider and precompute its edges
  logic signed [SUM_W-1:0]  row_left_r, row_right_r, row_top_r, row_bottom_r;
  logic [NUM_KINDS-1:0]     row_react_r;
  logic                     row_rx_r;
  logic [IDX_W-1:0]         row_idx_r;
  logic                     row_last_r;

  logic signed [SUM_W-1:0]  sel_left, sel_top;
  logic [KIND_W-1:0]        sel_kind;
  logic [TPM_IDX_W-1:0]     tpm_base;
  logic [NUM_KINDS-1:0]     sel_react;

  assign sel_left = SUM_W'(left_r[cmd.row_idx]);
  assign sel_top  = SUM_W'(top_r[cmd.row_idx]);
  assign sel_kind = kind_r[cmd.row_idx];
  assign tpm_base = TPM_IDX_W'(sel_kind) * TPM_IDX_W'(NUM_KINDS);

  // Matrix row of the receiver's kind; kinds out of range react to nothing
  always_comb begin
    for (int o = 0; o < NUM_KINDS; o++) begin
      sel_react[o] = (sel_kind < KIND_W'(NUM_KINDS)) &&
                     tpm_r[tpm_base + TPM_IDX_W'(o)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      row_left_r   <= sel_left;
      row_top_r    <= sel_top;
      row_right_r  <= sel_left + $signed({2'b00, width_r[cmd.row_idx]});
      row_bottom_r <= sel_top + $signed({2'b00, height_r[cmd.row_idx]});
      row_react_r  <= sel_react;
      row_rx_r     <= en_r[cmd.row_idx] && rx_r[cmd.row_idx];
      row_idx_r    <= cmd.row_idx;
    end
    if (cmd.emit) row_last_r <= cmd.row_last;
  end

  // Partner lanes: each tests one stored collider against the latched row
  logic [MASK_W-1:0] hit;

  genvar j;
  generate
    for (j = 0; j < MASK_W; j++) begin : g_lane
      if (j < LANES) begin : g_used
        logic signed [SUM_W-1:0] b_left, b_top, b_right, b_bottom;
        logic                    overlap, kind_ok, lane_ok;
        assign b_left   = SUM_W'(left_r[j]);
        assign b_top    = SUM_W'(top_r[j]);
        assign b_right  = b_left + $signed({2'b00, width_r[j]});
        assign b_bottom = b_top + $signed({2'b00, height_r[j]});
        // Strict overlap: touching edges do not count
        assign overlap  = (row_left_r < b_right) && (row_right_r > b_left) &&
                          (row_top_r < b_bottom) && (row_bottom_r > b_top);
        assign kind_ok  = (kind_r[j] < KIND_W'(NUM_KINDS)) &&
                          row_react_r[kind_r[j]];
        assign lane_ok  = (CNT_W'(j) < count_r) && (IDX_W'(j) != row_idx_r) &&
                          en_r[j];
        assign hit[j]   = row_rx_r && lane_ok && overlap && kind_ok;
      end else begin : g_unused
        assign hit[j] = 1'b0;
      end
    end
  endgenerate

  // Result word registers, one-cycle strobe
  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [MASK_W-1:0]    out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot_r <= SLOT_W'(row_idx_r);
      out_mask_r <= hit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_receiver_slot = out_slot_r;
  assign out_partner_mask  = out_mask_r;
  assign out_row_last      = row_last_r;

endmodule

### rtl/all_pairs_box_overlap_filter_core.sv
// Top level of the all-pairs box overlap filter.
// Colliders load one word per cycle while busy is low; a word with
// in_final_entry set closes the set (words beyond 32 are dropped, the final
// flag still counts). busy then rises and the block emits one result word
// per stored collider in load order, each on out_valid for one cycle, with
// a row select step and then all 32 partner lanes in parallel for each
// word. Results cannot be stalled: the receiver must take each word in the
// cycle it is shown. The table is empty again when busy falls.
// type_pair_mask may be written through the cfg_ channel at any time the
// block is idle.
module all_pairs_box_overlap_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [apof_pkg::COORD_W-1:0] in_box_left,
  input  logic signed [apof_pkg::COORD_W-1:0] in_box_top,
  input  logic [apof_pkg::SIZE_W-1:0]         in_box_width,
  input  logic [apof_pkg::SIZE_W-1:0]         in_box_height,
  input  logic [apof_pkg::KIND_W-1:0]         in_kind,
  input  logic                                in_enabled,
  input  logic                                in_has_receiver,
  input  logic                                in_final_entry,
  output logic                                out_valid,
  output logic [apof_pkg::SLOT_W-1:0]         out_receiver_slot,
  output logic [apof_pkg::MASK_W-1:0]         out_partner_mask,
  output logic                                out_row_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apof_pkg::TPM_W-1:0]          cfg_data
);
  import apof_pkg::*;

  apof_cmd_t  cmd;
  apof_stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  apof_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_final_entry (in_final_entry),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy)
  );

  apof_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_box_left       (in_box_left),
    .in_box_top        (in_box_top),
    .in_box_width      (in_box_width),
    .in_box_height     (in_box_height),
    .in_kind           (in_kind),
    .in_enabled        (in_enabled),
    .in_has_receiver   (in_has_receiver),
    .out_valid         (out_valid),
    .out_receiver_slot (out_receiver_slot),
    .out_partner_mask  (out_partner_mask),
    .out_row_last      (out_row_last)
  );

endmodule

### rtl/apof_checker.sv
// Port-level checker for the overlap filter and its bind.
module apof_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_final_entry,
  input logic                        out_valid,
  input logic [apof_pkg::SLOT_W-1:0] out_receiver_slot,
  input logic [apof_pkg::MASK_W-1:0] out_partner_mask,
  input logic                        out_row_last
);
  import apof_pkg::*;

  // A final word always starts a pass
  a_final_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_final_entry |=> busy)
    else $error("final word did not start a pass");

  // Rows before the last one leave the block busy
  a_mid_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_last |-> busy)
    else $error("non-final row shown while idle");

  // Result words are never shown back to back
  a_row_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result words back to back");

  // A collider is never its own partner
  a_no_self_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_partner_mask[out_receiver_slot])
    else $error("self bit set in partner mask");

endmodule

bind all_pairs_box_overlap_filter_core apof_checker u_apof_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_final_entry    (in_final_entry),
  .out_valid         (out_valid),
  .out_receiver_slot (out_receiver_slot),
  .out_partner_mask  (out_partner_mask),
  .out_row_last      (out_row_last)
);
